### hw/rtl/rvlsu_pkg.sv
package rvlsu_pkg;

  localparam logic [6:0] OpcodeLoad  = 7'h03;
  localparam logic [6:0] OpcodeStore = 7'h23;

  localparam logic [2:0] F3Byte      = 3'd0;
  localparam logic [2:0] F3Half      = 3'd1;
  localparam logic [2:0] F3Word      = 3'd2;
  localparam logic [2:0] F3ByteU     = 3'd4;
  localparam logic [2:0] F3HalfU     = 3'd5;

  localparam logic [2:0] StatusOk         = 3'd0;
  localparam logic [2:0] StatusMisaligned = 3'd1;
  localparam logic [2:0] StatusFunct3     = 3'd2;
  localparam logic [2:0] StatusOpcode     = 3'd3;
  localparam logic [2:0] StatusRange      = 3'd4;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic        is_load;
    logic [2:0]  status;
    logic [4:0]  rd;
    logic [2:0]  funct3;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [3:0]  be;
  } lsu_entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        write_enable;
    logic [31:0] load_result;
    logic [4:0]  dest_index;
  } lsu_result_t;

endpackage

### hw/rtl/rv32i_load_store_unit.sv
// RV32I load/store unit with a private little-endian data memory of MEM_BYTES
// bytes, held as 32-bit words with byte write enables. The front decodes each
// transfer, forms the address and checks opcode, funct3 and alignment; a
// two-entry queue feeds the back, which checks the range and accesses the
// memory. Stores and failed accesses are answered from the idle state; a load
// also passes through a read state, because the memory read port is registered.
// After reset the back clears every memory word, one word per cycle, before it
// takes the first item; the input still fills the queue during that time.
// Every input transfer produces exactly one output transfer, in order.
module rv32i_load_store_unit #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: instruction[31:0], base_value[63:32], store_value[95:64].
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: dest_index[4:0], load_result[36:5], write_enable[37],
  // status[40:38], zero padding[47:41].
  output logic [47:0] m_axis_tdata
);

  rvlsu_pkg::lsu_entry_t  front_entry;
  rvlsu_pkg::lsu_entry_t  head_entry;
  rvlsu_pkg::lsu_result_t result;
  logic                   head_valid;
  logic                   head_ready;

  rvlsu_front u_front (
    .instruction_i (s_axis_tdata[31:0]),
    .base_value_i  (s_axis_tdata[63:32]),
    .store_value_i (s_axis_tdata[95:64]),
    .entry_o       (front_entry)
  );

  rvlsu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (front_entry),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head_entry)
  );

  rvlsu_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_valid_i  (head_valid),
    .entry_ready_o  (head_ready),
    .entry_i        (head_entry),
    .result_valid_o (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_o       (result)
  );

  assign m_axis_tdata = {7'd0, result.status, result.write_enable,
                         result.load_result, result.dest_index};

endmodule

### hw/rtl/rvlsu_front.sv
module rvlsu_front (
  input  logic [31:0]             instruction_i,
  input  logic [31:0]             base_value_i,
  input  logic [31:0]             store_value_i,
  output rvlsu_pkg::lsu_entry_t   entry_o
);

  logic [6:0]  opcode;
  logic [2:0]  funct3;
  logic [4:0]  rd;
  logic [11:0] imm;
  logic [31:0] addr;
  logic        is_load;
  logic        is_store;

  assign opcode   = instruction_i[6:0];
  assign rd       = instruction_i[11:7];
  assign funct3   = instruction_i[14:12];
  assign is_load  = (opcode == rvlsu_pkg::OpcodeLoad);
  assign is_store = (opcode == rvlsu_pkg::OpcodeStore);
  assign imm      = is_load ? instruction_i[31:20]
                            : {instruction_i[31:25], instruction_i[11:7]};
  assign addr     = base_value_i + {{20{imm[11]}}, imm};

  always_comb begin
    entry_o.is_load = is_load;
    entry_o.rd      = is_load ? rd : 5'd0;
    entry_o.funct3  = funct3;
    entry_o.addr    = addr;
    entry_o.wdata   = store_value_i;
    entry_o.be      = 4'b0000;
    entry_o.status  = rvlsu_pkg::StatusOk;

    unique case (funct3[1:0])
      2'd0: begin
        entry_o.wdata = {4{store_value_i[7:0]}};
        entry_o.be    = 4'b0001 << addr[1:0];
      end
      2'd1: begin
        entry_o.wdata = {2{store_value_i[15:0]}};
        entry_o.be    = addr[1] ? 4'b1100 : 4'b0011;
      end
      default: begin
        entry_o.be    = 4'b1111;
      end
    endcase

    if (!is_load && !is_store) begin
      entry_o.status = rvlsu_pkg::StatusOpcode;
    end else if ((funct3[1:0] == 2'd3) || (is_load && funct3 == 3'd6) ||
                 (is_store && funct3[2])) begin
      entry_o.status = rvlsu_pkg::StatusFunct3;
    end else if ((funct3[1:0] == 2'd1 && addr[0]) ||
                 (funct3[1:0] == 2'd2 && addr[1:0] != 2'd0)) begin
      entry_o.status = rvlsu_pkg::StatusMisaligned;
    end
  end

endmodule

### hw/rtl/rvlsu_fifo.sv
module rvlsu_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  rvlsu_pkg::lsu_entry_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output rvlsu_pkg::lsu_entry_t pop_data_o
);

  localparam int unsigned CntW = rvlsu_pkg::QueuePtrW + 1;

  rvlsu_pkg::lsu_entry_t              slot_q [rvlsu_pkg::QueueDepth];
  logic [rvlsu_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rvlsu_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]                    count_q, count_d;
  logic                               push;
  logic                               pop;

  assign push_ready_o = (count_q != CntW'(rvlsu_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == rvlsu_pkg::QueuePtrW'(rvlsu_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == rvlsu_pkg::QueuePtrW'(rvlsu_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/rvlsu_back.sv
module rvlsu_back #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   entry_valid_i,
  output logic                   entry_ready_o,
  input  rvlsu_pkg::lsu_entry_t  entry_i,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output rvlsu_pkg::lsu_result_t result_o
);

  localparam int unsigned Words = (MEM_BYTES + 3) / 4;
  localparam int unsigned WordW = (Words > 1) ? $clog2(Words) : 1;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StRead  = 2'd2;

  logic [31:0]            mem_q [Words];
  logic [31:0]            rdata_q;
  logic [1:0]             state_q, state_d;
  logic [WordW-1:0]       clr_q, clr_d;
  rvlsu_pkg::lsu_entry_t  load_q, load_d;
  rvlsu_pkg::lsu_result_t out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic                   mem_we;
  logic [3:0]             mem_be;
  logic [31:0]            mem_wdata;
  logic [WordW-1:0]       mem_widx;
  logic [WordW-1:0]       mem_ridx;
  logic                   pop;
  logic [32:0]            end_addr;
  logic                   range_bad;
  logic [2:0]             status;
  logic [7:0]             rbyte;
  logic [15:0]            rhalf;
  logic [31:0]            load_value;

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;
  assign entry_ready_o  = (state_q == StIdle) && (!out_valid_q || result_ready_i);
  assign pop            = entry_valid_i && entry_ready_o;

  always_comb begin
    unique case (entry_i.funct3[1:0])
      2'd0:    end_addr = {1'b0, entry_i.addr} + 33'd1;
      2'd1:    end_addr = {1'b0, entry_i.addr} + 33'd2;
      default: end_addr = {1'b0, entry_i.addr} + 33'd4;
    endcase
  end

  assign range_bad = (end_addr > 33'(MEM_BYTES));
  assign status    = (entry_i.status == rvlsu_pkg::StatusOk && range_bad)
                     ? rvlsu_pkg::StatusRange : entry_i.status;
  assign mem_ridx  = entry_i.addr[WordW+1:2];

  assign rbyte = rdata_q[{load_q.addr[1:0], 3'b000} +: 8];
  assign rhalf = load_q.addr[1] ? rdata_q[31:16] : rdata_q[15:0];

  always_comb begin
    unique case (load_q.funct3)
      rvlsu_pkg::F3Byte:  load_value = {{24{rbyte[7]}}, rbyte};
      rvlsu_pkg::F3ByteU: load_value = {24'd0, rbyte};
      rvlsu_pkg::F3Half:  load_value = {{16{rhalf[15]}}, rhalf};
      rvlsu_pkg::F3HalfU: load_value = {16'd0, rhalf};
      default:            load_value = rdata_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    load_d      = load_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_ready_i;
    mem_we      = 1'b0;
    mem_be      = entry_i.be;
    mem_wdata   = entry_i.wdata;
    mem_widx    = entry_i.addr[WordW+1:2];

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_be    = 4'b1111;
        mem_wdata = '0;
        mem_widx  = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == WordW'(Words - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (pop) begin
          if (status == rvlsu_pkg::StatusOk && entry_i.is_load) begin
            load_d  = entry_i;
            state_d = StRead;
          end else begin
            mem_we                 = (status == rvlsu_pkg::StatusOk);
            out_d.dest_index       = entry_i.rd;
            out_d.load_result      = '0;
            out_d.write_enable     = 1'b0;
            out_d.status           = status;
            out_valid_d            = 1'b1;
          end
        end
      end
      StRead: begin
        out_d.dest_index   = load_q.rd;
        out_d.load_result  = load_value;
        out_d.write_enable = (load_q.rd != 5'd0);
        out_d.status       = rvlsu_pkg::StatusOk;
        out_valid_d        = 1'b1;
        state_d            = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    load_q <= load_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (mem_be[b]) begin
          mem_q[mem_widx][8*b +: 8] <= mem_wdata[8*b +: 8];
        end
      end
    end
    rdata_q <= mem_q[mem_ridx];
  end

endmodule

### bench/testbench.sv
module testbench;

  localparam int unsigned MemBytes  = 65536;
  localparam int unsigned NumItems  = 1550;
  localparam int unsigned LongHold  = 400;
  localparam int unsigned DrainAt   = 700;
  localparam int unsigned TailWait  = 20;
  localparam int unsigned CycleCap  = 400000;

  localparam logic [6:0] OpcodeAluImm  = 7'h13;
  localparam logic [6:0] OpcodeAllOnes = 7'h7F;
  localparam logic [2:0] F3Unused3     = 3'd3;
  localparam logic [2:0] F3Unused6     = 3'd6;
  localparam logic [2:0] F3Unused7     = 3'd7;

  typedef enum int {ReadyAlways, ReadyCoinFlip, ReadySparse, ReadyPeriodic} ready_mode_e;

  class access_ledger;
    bit [7:0]               shadow_mem [MemBytes];
    rvlsu_pkg::lsu_result_t expected_results [$];
    int unsigned            mismatches;
    int unsigned            results_checked;

    function logic [2:0] access_status(logic [31:0] addr, int unsigned sz);
      if ((addr & (sz - 1)) != 0) begin
        return rvlsu_pkg::StatusMisaligned;
      end
      if ({1'b0, addr} + 33'(sz) > 33'(MemBytes)) begin
        return rvlsu_pkg::StatusRange;
      end
      return rvlsu_pkg::StatusOk;
    endfunction

    function rvlsu_pkg::lsu_result_t access_outcome(logic [31:0] ins, logic [31:0] base,
                                                    logic [31:0] sval);
      rvlsu_pkg::lsu_result_t r;
      logic [31:0] addr;
      logic [31:0] v;
      logic [11:0] imm;
      int unsigned sz;
      r = '0;
      if (ins[6:0] == rvlsu_pkg::OpcodeLoad) begin
        r.dest_index = ins[11:7];
        imm = ins[31:20];
        addr = base + {{20{imm[11]}}, imm};
        case (ins[14:12]) inside
          rvlsu_pkg::F3Byte, rvlsu_pkg::F3ByteU: sz = 1;
          rvlsu_pkg::F3Half, rvlsu_pkg::F3HalfU: sz = 2;
          rvlsu_pkg::F3Word: sz = 4;
          default: sz = 0;
        endcase
        if (sz == 0) begin
          r.status = rvlsu_pkg::StatusFunct3;
        end else begin
          r.status = access_status(addr, sz);
          if (r.status == rvlsu_pkg::StatusOk) begin
            v = '0;
            for (int i = 0; i < sz; i++) begin
              v |= 32'(shadow_mem[int'(addr) + i]) << (8 * i);
            end
            if (ins[14:12] == rvlsu_pkg::F3Byte && v[7]) begin
              v[31:8] = '1;
            end else if (ins[14:12] == rvlsu_pkg::F3Half && v[15]) begin
              v[31:16] = '1;
            end
            r.load_result = v;
            r.write_enable = (ins[11:7] != 5'd0);
          end
        end
      end else if (ins[6:0] == rvlsu_pkg::OpcodeStore) begin
        imm = {ins[31:25], ins[11:7]};
        addr = base + {{20{imm[11]}}, imm};
        if (ins[14:12] > rvlsu_pkg::F3Word) begin
          r.status = rvlsu_pkg::StatusFunct3;
        end else begin
          sz = 1 << ins[13:12];
          r.status = access_status(addr, sz);
          if (r.status == rvlsu_pkg::StatusOk) begin
            for (int i = 0; i < sz; i++) begin
              shadow_mem[int'(addr) + i] = sval[8 * i +: 8];
            end
          end
        end
      end else begin
        r.status = rvlsu_pkg::StatusOpcode;
      end
      return r;
    endfunction

    function void accept_access(logic [31:0] ins, logic [31:0] base, logic [31:0] sval);
      expected_results.push_back(access_outcome(ins, base, sval));
    endfunction

    function void check_result(logic [47:0] beat);
      rvlsu_pkg::lsu_result_t got;
      rvlsu_pkg::lsu_result_t want;
      got = beat[40:0];
      results_checked++;
      if (beat[47:41] != 7'd0) begin
        $display("%0t: padding expected 0, got %h", $time, beat[47:41]);
        mismatches++;
      end
      if (expected_results.size() == 0) begin
        $display("%0t: result with no access pending, got %h", $time, got);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.dest_index !== want.dest_index) begin
          $display("%0t: dest_index expected %0d, got %0d", $time,
                   want.dest_index, got.dest_index);
          mismatches++;
        end
        if (got.load_result !== want.load_result) begin
          $display("%0t: load_result expected %h, got %h", $time,
                   want.load_result, got.load_result);
          mismatches++;
        end
        if (got.write_enable !== want.write_enable) begin
          $display("%0t: write_enable expected %b, got %b", $time,
                   want.write_enable, got.write_enable);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  access_ledger book = new();
  int unsigned  cycles = 0;

  rv32i_load_store_unit #(
    .MEM_BYTES(MemBytes)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleCap) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      book.check_result(m_axis_tdata);
    end
  end

  initial begin
    ready_mode_e mode;
    int          span;
    int          phase;
    bit          held;
    logic        ready;
    mode = ReadyAlways;
    span = 0;
    phase = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && book.results_checked >= 300) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          mode = ready_mode_e'($urandom_range(0, 3));
          span = $urandom_range(20, 150);
        end
        span--;
        phase++;
        case (mode)
          ReadyAlways:   ready = 1'b1;
          ReadyCoinFlip: ready = ($urandom_range(0, 1) != 0);
          ReadySparse:   ready = ($urandom_range(0, 3) == 0);
          default:       ready = (phase % 4 != 0);
        endcase
        m_axis_tready <= ready;
      end
    end
  end

  function automatic logic [31:0] ls_word(bit is_store, logic [2:0] f3, logic [4:0] rd,
                                          logic [11:0] imm);
    logic [4:0] rs1;
    logic [4:0] rs2;
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    if (is_store) begin
      return {imm[11:5], rs2, rs1, f3, imm[4:0], rvlsu_pkg::OpcodeStore};
    end
    return {imm, rs1, f3, rd, rvlsu_pkg::OpcodeLoad};
  endfunction

  task automatic send(logic [31:0] ins, logic [31:0] base, logic [31:0] sval);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sval, base, ins};
    do @(posedge clk_i); while (!s_axis_tready);
    book.accept_access(ins, base, sval);
  endtask

  task automatic issue(bit is_store, logic [2:0] f3, logic [4:0] rd, logic [11:0] imm,
                       logic [31:0] base, logic [31:0] sval);
    send(ls_word(is_store, f3, rd, imm), base, sval);
  endtask

  task automatic send_access(bit is_store, logic [2:0] f3, logic [4:0] rd,
                             logic [31:0] addr, logic [31:0] sval);
    logic [11:0] imm;
    imm = 12'($urandom);
    issue(is_store, f3, rd, imm, addr - {{20{imm[11]}}, imm}, sval);
  endtask

  task automatic pause(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (book.expected_results.size() != 0);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned sz;
    int          r;
    bit          is_store;
    logic [2:0]  f3;
    logic [31:0] addr;
    logic [31:0] ins;
    pick = $urandom_range(0, 99);
    is_store = ($urandom_range(0, 1) != 0);
    if (is_store) begin
      case ($urandom_range(0, 2))
        0: f3 = rvlsu_pkg::F3Byte;
        1: f3 = rvlsu_pkg::F3Half;
        default: f3 = rvlsu_pkg::F3Word;
      endcase
    end else begin
      case ($urandom_range(0, 4))
        0: f3 = rvlsu_pkg::F3Byte;
        1: f3 = rvlsu_pkg::F3Half;
        2: f3 = rvlsu_pkg::F3Word;
        3: f3 = rvlsu_pkg::F3ByteU;
        default: f3 = rvlsu_pkg::F3HalfU;
      endcase
    end
    sz = 1 << f3[1:0];
    if (pick < 72) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        addr = $urandom_range(0, 63);
      end else if (r < 9) begin
        addr = $urandom_range(0, MemBytes - 1);
      end else begin
        addr = MemBytes - 1 - $urandom_range(0, 63);
      end
      addr &= ~(sz - 1);
      send_access(is_store, f3, 5'($urandom), addr, $urandom);
    end else if (pick < 82) begin
      if (f3[1:0] == 2'd0) begin
        f3[0] = 1'b1;
      end
      sz = 1 << f3[1:0];
      addr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, MemBytes - 1) : $urandom;
      if ((addr & (sz - 1)) == 0) begin
        addr[0] = 1'b1;
      end
      send_access(is_store, f3, 5'($urandom), addr, $urandom);
    end else if (pick < 90) begin
      addr = $urandom_range(MemBytes, 32'hFFFF_FFFF) & ~(sz - 1);
      send_access(is_store, f3, 5'($urandom), addr, $urandom);
    end else if (pick < 95) begin
      if (is_store) begin
        f3 = 3'($urandom_range(F3Unused3, F3Unused7));
      end else begin
        case ($urandom_range(0, 2))
          0: f3 = F3Unused3;
          1: f3 = F3Unused6;
          default: f3 = F3Unused7;
        endcase
      end
      send_access(is_store, f3, 5'($urandom), $urandom_range(0, 63), $urandom);
    end else begin
      ins = $urandom;
      send(ins, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] ins;
    int unsigned sent;
    int unsigned burst;
    bit          drained;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_access(1'b1, rvlsu_pkg::F3Word, 5'd0, 32'd0, 32'h8081_7F80);
    send_access(1'b0, rvlsu_pkg::F3Byte, 5'd1, 32'd0, $urandom);
    send_access(1'b0, rvlsu_pkg::F3ByteU, 5'd2, 32'd0, $urandom);
    send_access(1'b0, rvlsu_pkg::F3Half, 5'd3, 32'd2, $urandom);
    send_access(1'b0, rvlsu_pkg::F3HalfU, 5'd4, 32'd2, $urandom);
    send_access(1'b0, rvlsu_pkg::F3Word, 5'd5, 32'd0, $urandom);
    send_access(1'b0, rvlsu_pkg::F3Byte, 5'd6, 32'd1, $urandom);
    send_access(1'b1, rvlsu_pkg::F3Byte, 5'd0, 32'd5, 32'hFFFF_FFA5);
    send_access(1'b1, rvlsu_pkg::F3Half, 5'd0, 32'd6, 32'h1234_BEEF);
    send_access(1'b0, rvlsu_pkg::F3Word, 5'd0, 32'd4, $urandom);
    send_access(1'b0, rvlsu_pkg::F3Half, 5'd7, 32'd1, $urandom);
    send_access(1'b0, rvlsu_pkg::F3Word, 5'd8, 32'd2, $urandom);
    send_access(1'b1, rvlsu_pkg::F3Half, 5'd0, 32'd3, $urandom);
    send_access(1'b1, rvlsu_pkg::F3Word, 5'd0, 32'd6, $urandom);
    send_access(1'b0, F3Unused3, 5'd9, 32'd0, $urandom);
    send_access(1'b0, F3Unused6, 5'd10, 32'd0, $urandom);
    send_access(1'b0, F3Unused7, 5'd11, 32'd0, $urandom);
    send_access(1'b1, F3Unused3, 5'd0, 32'd0, $urandom);
    send_access(1'b1, F3Unused7, 5'd0, 32'd0, $urandom);
    ins = $urandom;
    ins[6:0] = OpcodeAluImm;
    send(ins, $urandom, $urandom);
    ins = $urandom;
    ins[6:0] = OpcodeAllOnes;
    send(ins, $urandom, $urandom);
    send_access(1'b1, rvlsu_pkg::F3Word, 5'd0, MemBytes - 4, 32'hFFFF_FFFF);
    send_access(1'b0, rvlsu_pkg::F3Word, 5'd31, MemBytes - 4, $urandom);
    send_access(1'b0, rvlsu_pkg::F3Byte, 5'd12, MemBytes, $urandom);
    send_access(1'b0, rvlsu_pkg::F3Word, 5'd13, 32'hFFFF_FFFC, $urandom);
    issue(1'b0, rvlsu_pkg::F3Word, 5'd14, 12'h7FF, 32'd1, $urandom);
    issue(1'b1, rvlsu_pkg::F3Byte, 5'd0, 12'h800, 32'h0000_0800, 32'h0000_005A);
    issue(1'b0, rvlsu_pkg::F3ByteU, 5'd15, 12'h800, 32'h0000_0800, $urandom);
    issue(1'b0, rvlsu_pkg::F3Byte, 5'd16, 12'h800, 32'd0, $urandom);

    sent = 0;
    drained = 1'b0;
    while (sent < NumItems) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < NumItems; b++) begin
        random_item();
        sent++;
      end
      if (!drained && sent >= DrainAt) begin
        drained = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (TailWait) @(posedge clk_i);
    if (book.mismatches == 0 && book.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
